/* src/fixed_timeout_timer_queue_defines.svh */
// Assertion macros used by the timer queue datapath.
`ifndef FIXED_TIMEOUT_TIMER_QUEUE_DEFINES_SVH
`define FIXED_TIMEOUT_TIMER_QUEUE_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define FTQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define FTQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/ftq_pkg.sv */
// Shared types and constants of the fixed-timeout timer queue.
`default_nettype none

package ftq_pkg;

  // Default queue geometry.
  localparam int DEF_QUEUE_DEPTH = 32;
  localparam int DEF_TAG_BITS    = 16;

  // A tick pops at most this many expired entries.
  localparam int MAX_POPS  = 32;
  localparam int POP_CNT_W = $clog2(MAX_POPS + 1);

  // Field and register widths.
  localparam int TIME_W    = 32;
  localparam int IO_TAG_W  = 16;
  localparam int KIND_W    = 2;
  localparam int TIMEOUT_W = 16;
  localparam int MAXENT_W  = 6;
  localparam int SLACK_W   = 10;
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;

  // Register reset values.
  localparam logic [TIMEOUT_W-1:0] DEF_TIMEOUT_MS  = 16'd1000;
  localparam logic [MAXENT_W-1:0]  DEF_MAX_ENTRIES = 6'd32;
  localparam logic [SLACK_W-1:0]   DEF_SLACK_MS    = 10'd10;

  // Operation codes of an input transaction.
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_ADD  = 1'b1;

  // Register indexes (byte address bits [3:2]).
  localparam logic [1:0] REG_TIMEOUT     = 2'd0;
  localparam logic [1:0] REG_MAX_ENTRIES = 2'd1;
  localparam logic [1:0] REG_SLACK       = 2'd2;

  // Result kinds.
  typedef enum logic [KIND_W-1:0] {
    KIND_ADDED   = 2'd0,
    KIND_FULL    = 2'd1,
    KIND_EXPIRED = 2'd2
  } kind_t;

  // Configuration register contents.
  typedef struct packed {
    logic [TIMEOUT_W-1:0] timeout_ms;
    logic [MAXENT_W-1:0]  max_entries;
    logic [SLACK_W-1:0]   slack_ms;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic in_ready;
    logic take_add;
    logic take_tick;
    logic pop;
    logic flush;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic head_due;
    logic pend_valid;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

/* src/ftq_if.sv */
// Valid/ready channel interfaces for timer queue requests and results.
`default_nettype none

interface ftq_in_if;
  import ftq_pkg::*;

  logic                valid;
  logic                ready;
  logic                operation;
  logic [IO_TAG_W-1:0] timer_tag;

  modport source (output valid, output operation, output timer_tag, input ready);
  modport sink   (input valid, input operation, input timer_tag, output ready);
endinterface

interface ftq_out_if;
  import ftq_pkg::*;

  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [IO_TAG_W-1:0] tag;
  logic                last;

  modport source (output valid, output kind, output tag, output last, input ready);
  modport sink   (input valid, input kind, input tag, input last, output ready);
endinterface

`default_nettype wire

/* src/fixed_timeout_timer_queue.sv */
// Top level of the fixed-timeout timer queue: register file, controller and datapath.
//
// Usage: in_ch carries one transaction per request: operation 1 adds a timer with
// timer_tag, operation 0 is a one-millisecond tick. out_ch returns results
// (kind, tag, last); last marks the final result of a request. An add gives one
// result, accepted or rejected full. A tick advances the clock and pops expired
// timers from the head in FIFO order, up to 32 per tick; a quiet tick gives none.
// An add result is valid the cycle after acceptance. A tick reads the queue head
// and pops each due head into a held-back entry that settles the last flag; that
// entry goes to the result register on the next pop or on the closing flush. One
// RAM read of the queue head per cycle, while the result register is free, sets the pace.
// Requests are taken one at a time; the next one is taken once the result
// register is free. A stalled receiver holds the result and pauses popping.
// Reset (synchronous, rst_n low) empties the queue, clears the clock and loads
// the register defaults; no memory clearing pass is needed.
// Registers (APB, byte addresses): 0x0 timeout_ms, 0x4 max_entries, 0x8 slack_ms.
`default_nettype none

module fixed_timeout_timer_queue #(
  parameter int QUEUE_DEPTH = ftq_pkg::DEF_QUEUE_DEPTH,
  parameter int TAG_BITS    = ftq_pkg::DEF_TAG_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  ftq_in_if.sink                             in_ch,
  ftq_out_if.source                          out_ch,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ftq_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [ftq_pkg::PDATA_W-1:0]   pwdata,
  output      logic [ftq_pkg::PDATA_W-1:0]   prdata,
  output      logic                          pready
);
  import ftq_pkg::*;

  cfg_t       cfg_r;
  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       cfg_wr;
  logic [1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[3:2];

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.timeout_ms  <= DEF_TIMEOUT_MS;
      cfg_r.max_entries <= DEF_MAX_ENTRIES;
      cfg_r.slack_ms    <= DEF_SLACK_MS;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_TIMEOUT:     cfg_r.timeout_ms  <= pwdata[TIMEOUT_W-1:0];
        REG_MAX_ENTRIES: cfg_r.max_entries <= pwdata[MAXENT_W-1:0];
        REG_SLACK:       cfg_r.slack_ms    <= pwdata[SLACK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Configuration register reads.
  always_comb begin
    case (cfg_idx)
      REG_TIMEOUT:     prdata = PDATA_W'(cfg_r.timeout_ms);
      REG_MAX_ENTRIES: prdata = PDATA_W'(cfg_r.max_entries);
      REG_SLACK:       prdata = PDATA_W'(cfg_r.slack_ms);
      default:         prdata = '0;
    endcase
  end

  ftq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_op    (in_ch.operation),
    .status   (status),
    .cmd      (cmd)
  );

  assign in_ch.ready = cmd.in_ready;

  ftq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TAG_BITS    (TAG_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .cmd          (cmd),
    .in_timer_tag (in_ch.timer_tag),
    .out_ready    (out_ch.ready),
    .status       (status),
    .out_valid    (out_ch.valid),
    .out_kind     (out_ch.kind),
    .out_tag      (out_ch.tag),
    .out_last     (out_ch.last)
  );

endmodule

`default_nettype wire

/* src/ftq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ftq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_data <= mem_r[rd_addr];
  end

endmodule

`default_nettype wire

/* src/ftq_ctrl.sv */
// Controller state machine of the timer queue: accepts transactions and sequences pops.
`default_nettype none

module ftq_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic                in_op,
  input  wire ftq_pkg::dp_status_t status,
  output      ftq_pkg::ctrl_cmd_t  cmd
);
  import ftq_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_CHECK
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Next state and commands.
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        // One transaction at a time; a free result slot is needed to take any request.
        cmd.in_ready = status.out_free;
        if (in_valid && status.out_free) begin
          if (in_op == OP_ADD) begin
            cmd.take_add = 1'b1;
          end else begin
            cmd.take_tick = 1'b1;
            state_nxt     = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        // The head entry read is valid here; pop it, or close out the tick.
        if (status.head_due) begin
          if (!status.pend_valid || status.out_free) begin
            cmd.pop = 1'b1;
          end
        end else if (status.pend_valid) begin
          if (status.out_free) begin
            cmd.flush = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

/* src/ftq_dp.sv */
// Datapath of the timer queue: clock, queue pointers, entry RAM and result register.
`default_nettype none
`include "fixed_timeout_timer_queue_defines.svh"

module ftq_dp #(
  parameter int QUEUE_DEPTH = ftq_pkg::DEF_QUEUE_DEPTH,
  parameter int TAG_BITS    = ftq_pkg::DEF_TAG_BITS
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire ftq_pkg::cfg_t                  cfg,
  input  wire ftq_pkg::ctrl_cmd_t             cmd,
  input  wire logic [ftq_pkg::IO_TAG_W-1:0]   in_timer_tag,
  input  wire logic                           out_ready,
  output      ftq_pkg::dp_status_t            status,
  output      logic                           out_valid,
  output      logic [ftq_pkg::KIND_W-1:0]     out_kind,
  output      logic [ftq_pkg::IO_TAG_W-1:0]   out_tag,
  output      logic                           out_last
);
  import ftq_pkg::*;

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int CMP_W = (CNT_W > MAXENT_W) ? CNT_W : MAXENT_W;
  localparam int ENT_W = TIME_W + TAG_BITS;

  logic [TIME_W-1:0]    now_r;
  logic [IDX_W-1:0]     head_r;
  logic [IDX_W-1:0]     tail_r;
  logic [CNT_W-1:0]     count_r;
  logic [POP_CNT_W-1:0] pops_r;
  logic                 pend_valid_r;
  logic [TAG_BITS-1:0]  pend_tag_r;
  logic                 out_valid_r;
  kind_t                out_kind_r;
  logic [IO_TAG_W-1:0]  out_tag_r;
  logic                 out_last_r;

  logic [IDX_W-1:0]     head_inc;
  logic [IDX_W-1:0]     tail_inc;
  logic [IDX_W-1:0]     rd_addr;
  logic                 full;
  logic                 add_ok;
  logic [TAG_BITS-1:0]  add_tag;
  logic [ENT_W-1:0]     wr_data;
  logic [ENT_W-1:0]     rd_data;
  logic [TIME_W-1:0]    rd_expiry;
  logic [TAG_BITS-1:0]  rd_tag;
  logic [TIME_W-1:0]    remain;
  logic                 head_due;
  logic                 out_free;
  logic                 load_out;

  // Circular pointer increments.
  assign head_inc = (head_r == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign tail_inc = (tail_r == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : tail_r + 1'b1;

  // Occupancy limit: the programmed maximum or the physical depth.
  assign full    = (count_r >= CNT_W'(QUEUE_DEPTH)) ||
                   (CMP_W'(count_r) >= CMP_W'(cfg.max_entries));
  assign add_ok  = cmd.take_add && !full;
  assign add_tag = TAG_BITS'(in_timer_tag);
  assign wr_data = {now_r + TIME_W'(cfg.timeout_ms), add_tag};

  // Look ahead to the next head while popping, so one pop fits in each cycle unless the result register is busy.
  assign rd_addr = cmd.pop ? head_inc : head_r;

  ftq_ram #(
    .WIDTH (ENT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (add_ok),
    .wr_addr (tail_r),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_expiry = rd_data[ENT_W-1:TAG_BITS];
  assign rd_tag    = rd_data[TAG_BITS-1:0];

  // Expiry test on the signed wrapping distance to the head's deadline.
  assign remain   = rd_expiry - now_r;
  assign head_due = (count_r != '0) && (pops_r < POP_CNT_W'(MAX_POPS)) &&
                    (remain[TIME_W-1] || (remain <= TIME_W'(cfg.slack_ms)));

  assign out_free = !out_valid_r || out_ready;
  assign load_out = cmd.take_add || (cmd.pop && pend_valid_r) || cmd.flush;

  assign status.head_due   = head_due;
  assign status.pend_valid = pend_valid_r;
  assign status.out_free   = out_free;

  // Queue pointers, millisecond clock and per-tick pop count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r   <= '0;
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
      pops_r  <= '0;
    end else begin
      if (cmd.take_tick) begin
        now_r  <= now_r + 1'b1;
        pops_r <= '0;
      end
      if (add_ok) begin
        tail_r  <= tail_inc;
        count_r <= count_r + 1'b1;
      end
      if (cmd.pop) begin
        head_r  <= head_inc;
        count_r <= count_r - 1'b1;
        pops_r  <= pops_r + 1'b1;
      end
    end
  end

  // The most recent pop is held back until it is known whether it is the last.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
    end else if (cmd.pop) begin
      pend_valid_r <= 1'b1;
    end else if (cmd.flush) begin
      pend_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      pend_tag_r <= rd_tag;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (cmd.take_add) begin
      out_kind_r <= full ? KIND_FULL : KIND_ADDED;
      out_tag_r  <= IO_TAG_W'(add_tag);
      out_last_r <= 1'b1;
    end else if (cmd.pop && pend_valid_r) begin
      out_kind_r <= KIND_EXPIRED;
      out_tag_r  <= IO_TAG_W'(pend_tag_r);
      out_last_r <= 1'b0;
    end else if (cmd.flush) begin
      out_kind_r <= KIND_EXPIRED;
      out_tag_r  <= IO_TAG_W'(pend_tag_r);
      out_last_r <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_tag   = out_tag_r;
  assign out_last  = out_last_r;

  // The occupancy never passes the physical depth.
  `FTQ_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CNT_W'(QUEUE_DEPTH), "queue occupancy overflow")
  // An accepted add grows the queue by exactly one entry.
  `FTQ_ASSERT_NEXT(a_add_grows, add_ok, count_r == CNT_W'($past(count_r) + 1'b1), "add count slip")
  // A waiting result is never overwritten before it is taken.
  `FTQ_ASSERT_NOW(a_no_overwrite, load_out && out_valid_r, out_ready, "result overwritten")

endmodule

`default_nettype wire
